### hw/rtl/header_tail_deframer_with_error_rate_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the deframer top level
// Two helpers for clocked properties that are disabled while reset is active.
// ---------------------------------------------------------------------------
`ifndef HEADER_TAIL_DEFRAMER_WITH_ERROR_RATE_TOP_MACROS_SVH
`define HEADER_TAIL_DEFRAMER_WITH_ERROR_RATE_TOP_MACROS_SVH

// Same-cycle implication.
`define HDTL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HDTL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/hdtl_pkg.sv
// ---------------------------------------------------------------------------
// hdtl_pkg
// Shared constants, codes and types of the header/tail deframer.
// ---------------------------------------------------------------------------
package hdtl_pkg;

  localparam int MAX_PAYLOAD = 64;
  localparam int TAIL_BYTES  = 4;
  localparam int DROP_EXTRA  = 5;
  localparam int BODY_DEPTH  = MAX_PAYLOAD + TAIL_BYTES;
  localparam int RAM_DEPTH   = 2 * BODY_DEPTH;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int CNT_W       = $clog2(BODY_DEPTH + 2);
  localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 2;
  localparam int IDX_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int FRAME_LEN_W = 7;
  localparam int TOTAL_W     = 32;
  localparam int TAIL_W      = 32;
  localparam int SCALE_W     = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = TOTAL_W + SCALE_W;
  localparam int STEP_W      = $clog2(PROD_W);

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cmd_t CMD_BYTE    = 2'd0;
  localparam cmd_t CMD_LINE    = 2'd1;
  localparam cmd_t CMD_RELEASE = 2'd2;
  localparam cmd_t CMD_READ    = 2'd3;

  localparam status_t ST_TAKEN    = 3'd0;
  localparam status_t ST_STRAY    = 3'd1;
  localparam status_t ST_QUEUED   = 3'd2;
  localparam status_t ST_DROPPED  = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;
  localparam status_t ST_LINE_ERR = 3'd5;
  localparam status_t ST_RELEASED = 3'd6;
  localparam status_t ST_READ     = 3'd7;

  localparam cfg_idx_t CFG_HEADER = 2'd0;
  localparam cfg_idx_t CFG_TAIL   = 2'd1;
  localparam cfg_idx_t CFG_SCALE  = 2'd2;

  localparam logic [BYTE_W-1:0]  HEADER_RST = 8'd238;
  localparam logic [TAIL_W-1:0]  TAIL_RST   = 32'hFFFC_FFFF;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 20'd1000000;

  // Outcome of one parser step, handed to the sequencer.
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] err_add;
  } parse_res_t;

  // Payload length as it appears on the result port.
  function automatic logic [FRAME_LEN_W-1:0] len_field(logic [LEN_W-1:0] len);
    logic [FRAME_LEN_W+LEN_W-1:0] wide;
    wide = {{FRAME_LEN_W{1'b0}}, len};
    return wide[FRAME_LEN_W-1:0];
  endfunction

endpackage

### hw/rtl/hdtl_ram.sv
// ---------------------------------------------------------------------------
// hdtl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module hdtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/hdtl_parse.sv
// ---------------------------------------------------------------------------
// hdtl_parse
// Frame parser: header hunt, body capture, tail match and the pending slot.
// ---------------------------------------------------------------------------
module hdtl_parse (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  hdtl_pkg::cmd_t                  cmd_i,
  input  logic [hdtl_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic [hdtl_pkg::IDX_W-1:0]      read_index_i,
  input  logic [hdtl_pkg::BYTE_W-1:0]     header_i,
  input  logic [hdtl_pkg::TAIL_W-1:0]     tail_i,
  output hdtl_pkg::parse_res_t            res_o,
  output logic [hdtl_pkg::LEN_W-1:0]      pend_len_o,
  output logic                            pend_flag_o,
  output logic [hdtl_pkg::BYTE_W-1:0]     read_data_o
);
  import hdtl_pkg::*;

  logic              in_body_q, in_body_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [TAIL_W-1:0] last_q, last_d, last_nxt;
  logic              bank_q, bank_d, wbank;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              flag_q, flag_d;
  logic              rd_ok_q, rd_ok_d;
  logic              we;
  logic [RAM_AW-1:0] waddr, raddr;
  logic [BYTE_W-1:0] rdata;

  // The slot and the body live in two banks of one RAM; queuing a frame
  // swaps the banks instead of copying the payload.
  assign wbank    = ~bank_q;
  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign last_nxt = {last_q[TAIL_W-BYTE_W-1:0], data_byte_i};
  assign waddr    = wbank ? RAM_AW'(BODY_DEPTH) + RAM_AW'(cnt_q) : RAM_AW'(cnt_q);
  assign raddr    = bank_q ? RAM_AW'(BODY_DEPTH) + RAM_AW'(read_index_i)
                           : RAM_AW'(read_index_i);

  always_comb begin
    in_body_d      = in_body_q;
    cnt_d          = cnt_q;
    last_d         = last_q;
    bank_d         = bank_q;
    len_d          = len_q;
    flag_d         = flag_q;
    rd_ok_d        = rd_ok_q;
    we             = 1'b0;
    res_o.status   = ST_TAKEN;
    res_o.err_add  = '0;
    if (start_i) begin
      rd_ok_d = 1'b0;
      unique case (cmd_i)
        CMD_BYTE: begin
          priority if (!in_body_q) begin
            if (data_byte_i == header_i) begin
              in_body_d = 1'b1;
              cnt_d     = '0;
            end else begin
              res_o.status  = ST_STRAY;
              res_o.err_add = CNT_W'(1);
            end
          end else if (cnt_q >= CNT_W'(BODY_DEPTH)) begin
            res_o.status  = ST_OVERFLOW;
            res_o.err_add = cnt_inc;
            cnt_d         = '0;
            in_body_d     = (data_byte_i == header_i);
          end else begin
            we     = 1'b1;
            cnt_d  = cnt_inc;
            last_d = last_nxt;
            if (cnt_inc >= CNT_W'(TAIL_BYTES) && last_nxt == tail_i) begin
              cnt_d     = '0;
              in_body_d = 1'b0;
              if (flag_q) begin
                res_o.status  = ST_DROPPED;
                res_o.err_add = cnt_inc - CNT_W'(TAIL_BYTES) + CNT_W'(DROP_EXTRA);
              end else begin
                res_o.status = ST_QUEUED;
                len_d        = LEN_W'(cnt_inc - CNT_W'(TAIL_BYTES));
                flag_d       = 1'b1;
                bank_d       = wbank;
              end
            end
          end
        end
        CMD_LINE: begin
          res_o.status  = ST_LINE_ERR;
          res_o.err_add = CNT_W'(1);
        end
        CMD_RELEASE: begin
          res_o.status = ST_RELEASED;
          flag_d       = 1'b0;
        end
        CMD_READ: begin
          res_o.status = ST_READ;
          rd_ok_d      = (32'(read_index_i) < 32'(len_q));
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q <= 1'b0;
      cnt_q     <= '0;
      last_q    <= '0;
      bank_q    <= 1'b0;
      len_q     <= '0;
      flag_q    <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      in_body_q <= in_body_d;
      cnt_q     <= cnt_d;
      last_q    <= last_d;
      bank_q    <= bank_d;
      len_q     <= len_d;
      flag_q    <= flag_d;
      rd_ok_q   <= rd_ok_d;
    end
  end

  hdtl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (data_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign read_data_o = rd_ok_q ? rdata : '0;
  assign pend_len_o  = len_q;
  assign pend_flag_o = flag_q;

endmodule

### hw/rtl/hdtl_rate.sv
// ---------------------------------------------------------------------------
// hdtl_rate
// Error rate unit: one registered multiply, then a shift-subtract divider
// that retires one quotient bit per cycle.
// ---------------------------------------------------------------------------
module hdtl_rate (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hdtl_pkg::TOTAL_W-1:0] err_i,
  input  logic [hdtl_pkg::TOTAL_W-1:0] rx_i,
  input  logic [hdtl_pkg::SCALE_W-1:0] scale_i,
  output logic                         done_o,
  output logic [hdtl_pkg::TOTAL_W-1:0] rate_o
);
  import hdtl_pkg::*;

  logic               busy_q, done_q, zero_q;
  logic [STEP_W-1:0]  step_q;
  logic [PROD_W-1:0]  pq_q, prod;
  logic [TOTAL_W-1:0] div_q, rem_q;
  logic [TOTAL_W:0]   shifted, diff;
  logic               fits;

  assign prod    = PROD_W'(err_i) * PROD_W'(scale_i);
  assign shifted = {rem_q, pq_q[PROD_W-1]};
  assign diff    = shifted - {1'b0, div_q};
  assign fits    = (shifted >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        zero_q <= (rx_i == '0);
        step_q <= STEP_W'(PROD_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - STEP_W'(1);
        end
      end
    end
  end

  // The product is shifted out from the top while quotient bits enter below.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pq_q  <= prod;
      div_q <= rx_i;
      rem_q <= '0;
    end else if (busy_q) begin
      pq_q  <= {pq_q[PROD_W-2:0], fits};
      rem_q <= fits ? diff[TOTAL_W-1:0] : shifted[TOTAL_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rate_o = zero_q ? '0 : pq_q[TOTAL_W-1:0];

endmodule

### hw/rtl/header_tail_deframer_with_error_rate_top.sv
// ---------------------------------------------------------------------------
// header_tail_deframer_with_error_rate_top: deframer with error statistics.
// Release and read words go from parsing straight to the result; byte and
// line-error words also run the 52-step divider; one word in flight at a time.
// Reset (async, low) hunts for a header and clears counters, slot and rate.
// ---------------------------------------------------------------------------
`include "header_tail_deframer_with_error_rate_top_macros.svh"

module header_tail_deframer_with_error_rate_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hdtl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hdtl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [hdtl_pkg::CMD_W-1:0]      cmd_i,
  input  logic [hdtl_pkg::BYTE_W-1:0]     data_byte_i,
  input  logic [hdtl_pkg::IDX_W-1:0]      read_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [hdtl_pkg::STATUS_W-1:0]   status_o,
  output logic [hdtl_pkg::FRAME_LEN_W-1:0] frame_length_o,
  output logic [hdtl_pkg::BYTE_W-1:0]     read_data_o,
  output logic                            frame_waiting_o,
  output logic [hdtl_pkg::TOTAL_W-1:0]    received_total_o,
  output logic [hdtl_pkg::TOTAL_W-1:0]    error_total_o,
  output logic [hdtl_pkg::TOTAL_W-1:0]    error_rate_o
);
  import hdtl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PARSE = 3'd1;
  localparam logic [2:0] S_RATE  = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [BYTE_W-1:0]  header_q;
  logic [TAIL_W-1:0]  tail_q;
  logic [SCALE_W-1:0] scale_q;
  cmd_t               cmd_q;
  logic [BYTE_W-1:0]  byte_q;
  logic [IDX_W-1:0]   idx_q;
  logic [TOTAL_W-1:0] rx_q, err_q, rate_q;
  status_t            status_q;
  parse_res_t         res;
  logic [LEN_W-1:0]   pend_len;
  logic               pend_flag;
  logic [BYTE_W-1:0]  rd_data;
  logic               rate_done;
  logic [TOTAL_W-1:0] rate_val;
  logic               accept, parse_go, load_out;
  logic               queued_shown;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign parse_go   = (state_q == S_PARSE);
  assign load_out   = (state_q == S_DONE) && (!out_valid_o || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_PARSE;
      S_PARSE: begin
        if (cmd_q == CMD_BYTE || cmd_q == CMD_LINE) begin
          state_d = S_RATE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RATE:  state_d = S_WAIT;
      S_WAIT:  if (rate_done) state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      header_q    <= HEADER_RST;
      tail_q      <= TAIL_RST;
      scale_q     <= SCALE_RST;
      rx_q        <= '0;
      err_q       <= '0;
      rate_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_HEADER: header_q <= cfg_data_i[BYTE_W-1:0];
          CFG_TAIL:   tail_q   <= cfg_data_i[TAIL_W-1:0];
          CFG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
          default:    ;
        endcase
      end
      if (parse_go) begin
        if (cmd_q == CMD_BYTE) begin
          rx_q <= rx_q + TOTAL_W'(1);
        end
        err_q <= err_q + TOTAL_W'(res.err_add);
      end
      if (state_q == S_WAIT && rate_done) begin
        rate_q <= rate_val;
      end
      if (load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      byte_q <= data_byte_i;
      idx_q  <= read_index_i;
    end
    if (parse_go) begin
      status_q <= res.status;
    end
    if (load_out) begin
      status_o         <= status_q;
      frame_length_o   <= len_field(pend_len);
      read_data_o      <= rd_data;
      frame_waiting_o  <= pend_flag;
      received_total_o <= rx_q;
      error_total_o    <= err_q;
      error_rate_o     <= rate_q;
    end
  end

  hdtl_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (parse_go),
    .cmd_i        (cmd_q),
    .data_byte_i  (byte_q),
    .read_index_i (idx_q),
    .header_i     (header_q),
    .tail_i       (tail_q),
    .res_o        (res),
    .pend_len_o   (pend_len),
    .pend_flag_o  (pend_flag),
    .read_data_o  (rd_data)
  );

  hdtl_rate u_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_RATE),
    .err_i   (err_q),
    .rx_i    (rx_q),
    .scale_i (scale_q),
    .done_o  (rate_done),
    .rate_o  (rate_val)
  );

  assign queued_shown = out_valid_o && (status_o == ST_QUEUED);

  // A queued frame must still be waiting when its result is shown.
  `HDTL_ASSERT_NOW(a_queued_waits, queued_shown, frame_waiting_o, "queued frame not flagged")
  // The divider only reports back while the sequencer waits for it.
  `HDTL_ASSERT_NOW(a_done_in_wait, rate_done, state_q == S_WAIT, "rate unit out of turn")
  // The error total moves only in the parse step.
  `HDTL_ASSERT_NEXT(a_err_stable, state_q != S_PARSE, $stable(err_q), "error count moved")

endmodule
